// ----- rtl/spc_pkg.sv -----
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants
// Field layout of the stream words, command codes, sequencer states and the
// control and status groups between the sequencer and the cap unit.
// ----------------------------------------------------------------------------
package spc_pkg;

	localparam int COORD_W = 32;
	localparam int LIMIT_W = 33;

	// input tuser: cmd
	localparam int CMD_W = 2;
	localparam logic [CMD_W-1:0] CMD_WRITE_CAP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET_COUNT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd2;

	// input tdata layout, lowest bit first
	localparam int POLY_W    = 8;
	localparam int SLOT_W    = 4;
	localparam int TOTAL_W   = 5;
	localparam int POLY_LSB  = 0;
	localparam int SLOT_LSB  = POLY_LSB + POLY_W;
	localparam int TOTAL_LSB = SLOT_LSB + SLOT_W;
	localparam int X_LSB     = TOTAL_LSB + TOTAL_W;
	localparam int Y_LSB     = X_LSB + COORD_W;
	localparam int Z_LSB     = Y_LSB + COORD_W;
	localparam int LIMIT_LSB = Z_LSB + COORD_W;
	localparam int IN_BITS   = LIMIT_LSB + LIMIT_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

	// output tdata layout: inside_res, query_poly
	localparam int OUT_BITS   = 1 + POLY_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// limits of the usable cap range, 2.0 in Q3.30
	localparam logic signed [LIMIT_W-1:0] LIM_POS_TWO = 33'sh0_8000_0000;
	localparam logic signed [LIMIT_W-1:0] LIM_NEG_TWO = 33'sh1_8000_0000;

	typedef struct packed {
		logic signed [LIMIT_W-1:0] limit;
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} cap_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COUNT,
		ST_ISSUE,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		logic issue;
	} unit_ctrl_t;

	typedef struct packed {
		logic busy;
		logic hit;
	} unit_stat_t;

endpackage

// ----- rtl/spherical_polygon_cap_test.sv -----
// ----------------------------------------------------------------------------
// spherical_polygon_cap_test: polygon membership test over spherical caps
// Holds a table of polygons made of caps and answers point queries.
// ----------------------------------------------------------------------------
// After reset the block zeroes the cap count of every polygon and takes no
// transfer meanwhile. Cap writes and count writes are taken while idle. A
// query first reads the polygon's count. An empty or out-of-range polygon
// goes straight to loading the answer; otherwise the cap memory port delivers
// one cap per cycle into a three-stage evaluator and the answer is loaded
// after it drains. Queries run one at a time; the next item is taken once the
// answer sits in the output register, even if it has not been taken yet.
module spherical_polygon_cap_test #(
	parameter int NUM_POLYS = 256,
	parameter int MAX_CAPS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// poly_index, cap_slot, cap_total, coord_x, coord_y, coord_z, limit_value
	input  logic [spc_pkg::IN_DATA_W-1:0]     s_tdata,
	// cmd
	input  logic [spc_pkg::CMD_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// inside_res, query_poly
	output logic [spc_pkg::OUT_DATA_W-1:0]    m_tdata
);

	localparam int PW = (NUM_POLYS > 1) ? $clog2(NUM_POLYS) : 1;
	localparam int DEPTH = NUM_POLYS * MAX_CAPS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(MAX_CAPS + 1);

	spc_pkg::state_t state_q, state_d;

	logic [PW-1:0]    clr_q;
	logic [AW-1:0]    addr_q;
	logic [CNT_W-1:0] remain_q;
	logic             oob_q;
	logic [spc_pkg::POLY_W-1:0] poly_q;
	logic             out_valid_q;
	logic             out_inside_q;
	logic [spc_pkg::POLY_W-1:0] out_poly_q;

	logic [spc_pkg::CMD_W-1:0]   in_cmd;
	logic [spc_pkg::POLY_W-1:0]  in_poly;
	logic [spc_pkg::SLOT_W-1:0]  in_slot;
	logic [spc_pkg::TOTAL_W-1:0] in_total;
	spc_pkg::cap_t               in_cap;
	logic [PW-1:0]               poly_addr;
	logic [AW-1:0]               cap_base;
	logic                        in_oob;
	logic                        accept;

	logic             cnt_we;
	logic [PW-1:0]    cnt_waddr;
	logic [CNT_W-1:0] cnt_wdata;
	logic [CNT_W-1:0] cnt_rdata;
	logic             cap_we;
	spc_pkg::cap_t    cap_rdata;
	logic             load_out;

	spc_pkg::unit_ctrl_t ctrl;
	spc_pkg::unit_stat_t stat;

	assign in_cmd = s_tuser;
	assign in_poly = s_tdata[spc_pkg::POLY_LSB +: spc_pkg::POLY_W];
	assign in_slot = s_tdata[spc_pkg::SLOT_LSB +: spc_pkg::SLOT_W];
	assign in_total = s_tdata[spc_pkg::TOTAL_LSB +: spc_pkg::TOTAL_W];
	assign in_cap.x = s_tdata[spc_pkg::X_LSB +: spc_pkg::COORD_W];
	assign in_cap.y = s_tdata[spc_pkg::Y_LSB +: spc_pkg::COORD_W];
	assign in_cap.z = s_tdata[spc_pkg::Z_LSB +: spc_pkg::COORD_W];
	assign in_cap.limit = s_tdata[spc_pkg::LIMIT_LSB +: spc_pkg::LIMIT_W];

	assign poly_addr = PW'(in_poly);
	assign cap_base = AW'(poly_addr) * AW'(MAX_CAPS);
	assign in_oob = (32'(in_poly) >= NUM_POLYS);
	assign accept = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		ctrl = '0;
		load_out = 1'b0;
		case (state_q)
			spc_pkg::ST_CLEAR: begin
				if (clr_q == PW'(NUM_POLYS - 1)) begin
					state_d = spc_pkg::ST_IDLE;
				end
			end
			spc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && in_cmd == spc_pkg::CMD_QUERY) begin
					ctrl.start = 1'b1;
					state_d = spc_pkg::ST_COUNT;
				end
			end
			spc_pkg::ST_COUNT: begin
				if (oob_q || cnt_rdata == '0) begin
					state_d = spc_pkg::ST_FINISH;
				end else begin
					state_d = spc_pkg::ST_ISSUE;
				end
			end
			spc_pkg::ST_ISSUE: begin
				ctrl.issue = 1'b1;
				if (remain_q == CNT_W'(1)) begin
					state_d = spc_pkg::ST_DRAIN;
				end
			end
			spc_pkg::ST_DRAIN: begin
				if (!stat.busy) begin
					state_d = spc_pkg::ST_FINISH;
				end
			end
			spc_pkg::ST_FINISH: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d = spc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = spc_pkg::ST_IDLE;
			end
		endcase
	end

	// count memory: zeroed by the clearing pass, written by set-count items
	always_comb begin
		if (state_q == spc_pkg::ST_CLEAR) begin
			cnt_we = 1'b1;
			cnt_waddr = clr_q;
			cnt_wdata = '0;
		end else begin
			cnt_we = accept && in_cmd == spc_pkg::CMD_SET_COUNT && !in_oob;
			cnt_waddr = poly_addr;
			cnt_wdata = (32'(in_total) > MAX_CAPS) ? CNT_W'(MAX_CAPS) : CNT_W'(in_total);
		end
	end

	assign cap_we = accept && in_cmd == spc_pkg::CMD_WRITE_CAP && !in_oob
		&& (32'(in_slot) < MAX_CAPS);

	spc_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NUM_POLYS)
	) u_count_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.re   (accept),
		.raddr(poly_addr),
		.rdata(cnt_rdata)
	);

	spc_ram #(
		.WIDTH($bits(spc_pkg::cap_t)),
		.DEPTH(DEPTH)
	) u_cap_ram (
		.clk  (clk),
		.we   (cap_we),
		.waddr(cap_base + AW'(in_slot)),
		.wdata(in_cap),
		.re   (ctrl.issue),
		.raddr(addr_q),
		.rdata(cap_rdata)
	);

	spc_cap_unit u_cap_unit (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.px    (in_cap.x),
		.py    (in_cap.y),
		.pz    (in_cap.z),
		.cap   (cap_rdata),
		.stat  (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spc_pkg::ST_CLEAR;
			clr_q <= '0;
			remain_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == spc_pkg::ST_CLEAR) begin
				clr_q <= clr_q + PW'(1);
			end
			if (state_q == spc_pkg::ST_COUNT) begin
				remain_q <= cnt_rdata;
			end else if (ctrl.issue) begin
				remain_q <= remain_q - CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			addr_q <= cap_base;
			oob_q <= in_oob;
			poly_q <= in_poly;
		end else if (ctrl.issue) begin
			addr_q <= addr_q + AW'(1);
		end
		if (load_out) begin
			out_inside_q <= !oob_q && stat.hit;
			out_poly_q <= poly_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = spc_pkg::OUT_DATA_W'({out_poly_q, out_inside_q});

`ifndef NO_ASSERTIONS
	a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spc_pkg::ST_IDLE |-> !stat.busy)
		else $error("cap unit busy while sequencer idle");

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spc_pkg::ST_CLEAR |-> !s_tready)
		else $error("input taken during clearing pass");

	a_issue_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spc_pkg::ST_ISSUE |-> remain_q != '0)
		else $error("cap issued past the polygon's count");

	a_finish_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spc_pkg::ST_FINISH && (!m_tvalid || m_tready)
		|=> m_tvalid && state_q == spc_pkg::ST_IDLE)
		else $error("query answer not loaded");
`endif

endmodule

// ----- rtl/spc_ram.sv -----
// ----------------------------------------------------------------------------
// spc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/spc_cap_unit.sv -----
// ----------------------------------------------------------------------------
// spc_cap_unit: pipelined cap evaluator
// Takes one cap per cycle from the cap memory, tests the held query point
// against it and folds the outcome into a running inside flag.
// ----------------------------------------------------------------------------
module spc_cap_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  spc_pkg::unit_ctrl_t                     ctrl,
	input  logic signed [spc_pkg::COORD_W-1:0]      px,
	input  logic signed [spc_pkg::COORD_W-1:0]      py,
	input  logic signed [spc_pkg::COORD_W-1:0]      pz,
	input  spc_pkg::cap_t                           cap,
	output spc_pkg::unit_stat_t                     stat
);

	localparam int CW = spc_pkg::COORD_W;
	localparam int SQ_W = 2 * CW;
	localparam int SUM_W = SQ_W + 2;

	logic signed [CW-1:0] px_q, py_q, pz_q;
	logic                 v_s1, v_s2, v_s3;
	logic                 inside_q;

	// stage 2: distances per axis and limit class
	logic [CW-1:0] ax_s2, ay_s2, az_s2, lmag_s2;
	logic          bad_s2, skip_s2, pos_s2;
	// stage 3: squares
	logic [SQ_W-1:0] sqx_s3, sqy_s3, sqz_s3;
	logic [CW-1:0]   lmag_s3;
	logic            bad_s3, skip_s3, pos_s3;

	logic [CW:0]          dx, dy, dz;
	logic [CW-1:0]        ax, ay, az;
	logic signed [spc_pkg::LIMIT_W-1:0] lneg;
	logic [SUM_W-1:0]     gap_sum;
	logic [SUM_W-1:0]     rhs;
	logic                 pass;

	function automatic logic [CW-1:0] abs_diff(input logic [CW:0] d);
		logic [CW:0] n;
		n = -d;
		return d[CW] ? n[CW-1:0] : d[CW-1:0];
	endfunction

	always_comb begin
		dx = {px_q[CW-1], px_q} - {cap.x[CW-1], cap.x};
		dy = {py_q[CW-1], py_q} - {cap.y[CW-1], cap.y};
		dz = {pz_q[CW-1], pz_q} - {cap.z[CW-1], cap.z};
		ax = abs_diff(dx);
		ay = abs_diff(dy);
		az = abs_diff(dz);
		lneg = -cap.limit;
	end

	always_comb begin
		gap_sum = {2'b00, sqx_s3} + {2'b00, sqy_s3} + {2'b00, sqz_s3};
		rhs = SUM_W'({lmag_s3, 31'd0});
		if (bad_s3) begin
			pass = 1'b0;
		end else if (skip_s3) begin
			pass = 1'b1;
		end else if (pos_s3) begin
			pass = (gap_sum <= rhs);
		end else begin
			pass = (gap_sum >= rhs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			inside_q <= 1'b1;
		end else begin
			v_s1 <= ctrl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (ctrl.start) begin
				inside_q <= 1'b1;
			end else if (v_s3) begin
				inside_q <= inside_q & pass;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			px_q <= px;
			py_q <= py;
			pz_q <= pz;
		end
		ax_s2 <= ax;
		ay_s2 <= ay;
		az_s2 <= az;
		lmag_s2 <= cap.limit[spc_pkg::LIMIT_W-1] ? lneg[CW-1:0] : cap.limit[CW-1:0];
		bad_s2 <= (cap.limit == '0) || (cap.limit < spc_pkg::LIM_NEG_TWO);
		skip_s2 <= (cap.limit > spc_pkg::LIM_POS_TWO);
		pos_s2 <= !cap.limit[spc_pkg::LIMIT_W-1];

		sqx_s3 <= ax_s2 * ax_s2;
		sqy_s3 <= ay_s2 * ay_s2;
		sqz_s3 <= az_s2 * az_s2;
		lmag_s3 <= lmag_s2;
		bad_s3 <= bad_s2;
		skip_s3 <= skip_s2;
		pos_s3 <= pos_s2;
	end

	assign stat.busy = v_s1 | v_s2 | v_s3;
	assign stat.hit = inside_q;

endmodule
